// ===== rtl/core/snd_rf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound unit register file package
// Register addresses, read masks and the register bundle passed from the
// storage to the read multiplexer.
// ----------------------------------------------------------------------------
package snd_rf_pkg;

  localparam logic [15:0] ADDR_SQ1_SWEEP    = 16'hFF10;
  localparam logic [15:0] ADDR_SQ1_DUTY     = 16'hFF11;
  localparam logic [15:0] ADDR_SQ1_ENV      = 16'hFF12;
  localparam logic [15:0] ADDR_SQ1_FREQ_LO  = 16'hFF13;
  localparam logic [15:0] ADDR_SQ1_FREQ_HI  = 16'hFF14;
  localparam logic [15:0] ADDR_SQ2_DUTY     = 16'hFF16;
  localparam logic [15:0] ADDR_SQ2_ENV      = 16'hFF17;
  localparam logic [15:0] ADDR_SQ2_FREQ_LO  = 16'hFF18;
  localparam logic [15:0] ADDR_SQ2_FREQ_HI  = 16'hFF19;
  localparam logic [15:0] ADDR_WAV_DAC      = 16'hFF1A;
  localparam logic [15:0] ADDR_WAV_LENGTH   = 16'hFF1B;
  localparam logic [15:0] ADDR_WAV_LEVEL    = 16'hFF1C;
  localparam logic [15:0] ADDR_WAV_FREQ_LO  = 16'hFF1D;
  localparam logic [15:0] ADDR_WAV_FREQ_HI  = 16'hFF1E;
  localparam logic [15:0] ADDR_NOISE_LENGTH = 16'hFF20;
  localparam logic [15:0] ADDR_NOISE_ENV    = 16'hFF21;
  localparam logic [15:0] ADDR_NOISE_DIV    = 16'hFF22;
  localparam logic [15:0] ADDR_NOISE_TRIG   = 16'hFF23;
  localparam logic [15:0] ADDR_MASTER_VOL   = 16'hFF24;
  localparam logic [15:0] ADDR_PANNING      = 16'hFF25;
  localparam logic [15:0] ADDR_POWER        = 16'hFF26;

  // Wave memory occupies 0xFF30 to 0xFF3F: the upper twelve bits select it.
  localparam logic [11:0] WAVE_PAGE = 12'hFF3;

  localparam logic [7:0] MASK_DUTY    = 8'hC0;
  localparam logic [7:0] MASK_TRIGGER = 8'h40;
  localparam logic [7:0] MASK_DAC     = 8'h80;
  localparam logic [7:0] MASK_LEVEL   = 8'h60;
  localparam logic [7:0] UNMAPPED     = 8'hFF;

  localparam int unsigned POWER_BIT   = 7;
  localparam int unsigned TRIGGER_BIT = 7;
  localparam int unsigned SQ1_ON_BIT  = 0;
  localparam int unsigned SQ2_ON_BIT  = 1;

  typedef logic [15:0][3:0] wave_mem_t;

  typedef struct packed {
    logic [7:0] sq1_sweep;
    logic [7:0] sq1_duty_length;
    logic [7:0] sq1_envelope;
    logic [7:0] sq1_freq_high;
    logic [7:0] sq2_duty_length;
    logic [7:0] sq2_envelope;
    logic [7:0] sq2_freq_high;
    logic [7:0] wav_dac_control;
    logic [7:0] wav_length;
    logic [7:0] wav_level;
    logic [7:0] wav_freq_high;
    logic [7:0] noise_length;
    logic [7:0] noise_envelope;
    logic [7:0] noise_divider;
    logic [7:0] noise_trigger_reg;
    logic [7:0] master_volume;
    logic [7:0] panning;
    logic [7:0] power_status;
    wave_mem_t  wave_memory;
  } regs_t;

endpackage

// ===== rtl/core/snd_rf_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound unit register storage
// Holds the channel, volume, panning and power registers and the wave memory,
// and applies one bus write per cycle.
// ----------------------------------------------------------------------------
module snd_rf_regs
  import snd_rf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output regs_t       regs
);

  logic [7:0] sq1_sweep, sq1_duty_length, sq1_envelope, sq1_freq_low, sq1_freq_high;
  logic [7:0] sq2_duty_length, sq2_envelope, sq2_freq_low, sq2_freq_high;
  logic [7:0] wav_dac_control, wav_length, wav_level, wav_freq_low, wav_freq_high;
  logic [7:0] noise_length, noise_envelope, noise_divider, noise_trigger_reg;
  logic [7:0] master_volume, panning, power_status;
  wave_mem_t  wave_memory;
  logic       power_on;

  assign power_on = power_status[POWER_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq1_sweep         <= '0;
      sq1_duty_length   <= '0;
      sq1_envelope      <= '0;
      sq1_freq_low      <= '0;
      sq1_freq_high     <= '0;
      sq2_duty_length   <= '0;
      sq2_envelope      <= '0;
      sq2_freq_low      <= '0;
      sq2_freq_high     <= '0;
      wav_dac_control   <= '0;
      wav_length        <= '0;
      wav_level         <= '0;
      wav_freq_low      <= '0;
      wav_freq_high     <= '0;
      noise_length      <= '0;
      noise_envelope    <= '0;
      noise_divider     <= '0;
      noise_trigger_reg <= '0;
      master_volume     <= '0;
      panning           <= '0;
      power_status      <= '0;
      wave_memory       <= '0;
    end else if (wr_en) begin
      priority if (address[15:4] == WAVE_PAGE) begin
        // Wave memory is writable whatever the power state.
        wave_memory[address[3:0]] <= write_data[3:0];
      end else if (address == ADDR_POWER) begin
        power_status <= {write_data[POWER_BIT], 7'b0};
        if (!write_data[POWER_BIT]) begin
          // Powering down clears everything except the wave memory.
          sq1_sweep         <= '0;
          sq1_duty_length   <= '0;
          sq1_envelope      <= '0;
          sq1_freq_low      <= '0;
          sq1_freq_high     <= '0;
          sq2_duty_length   <= '0;
          sq2_envelope      <= '0;
          sq2_freq_low      <= '0;
          sq2_freq_high     <= '0;
          wav_dac_control   <= '0;
          wav_length        <= '0;
          wav_level         <= '0;
          wav_freq_low      <= '0;
          wav_freq_high     <= '0;
          noise_length      <= '0;
          noise_envelope    <= '0;
          noise_divider     <= '0;
          noise_trigger_reg <= '0;
          master_volume     <= '0;
          panning           <= '0;
        end
      end else if (power_on) begin
        unique case (address)
          ADDR_SQ1_SWEEP:    sq1_sweep <= write_data;
          ADDR_SQ1_DUTY:     sq1_duty_length <= write_data;
          ADDR_SQ1_ENV:      sq1_envelope <= write_data;
          ADDR_SQ1_FREQ_LO:  sq1_freq_low <= write_data;
          ADDR_SQ1_FREQ_HI: begin
            sq1_freq_high <= write_data;
            if (write_data[TRIGGER_BIT]) power_status[SQ1_ON_BIT] <= 1'b1;
          end
          ADDR_SQ2_DUTY:     sq2_duty_length <= write_data;
          ADDR_SQ2_ENV:      sq2_envelope <= write_data;
          ADDR_SQ2_FREQ_LO:  sq2_freq_low <= write_data;
          ADDR_SQ2_FREQ_HI: begin
            sq2_freq_high <= write_data;
            if (write_data[TRIGGER_BIT]) power_status[SQ2_ON_BIT] <= 1'b1;
          end
          ADDR_WAV_DAC:      wav_dac_control <= write_data;
          ADDR_WAV_LENGTH:   wav_length <= write_data;
          ADDR_WAV_LEVEL:    wav_level <= write_data;
          ADDR_WAV_FREQ_LO:  wav_freq_low <= write_data;
          ADDR_WAV_FREQ_HI:  wav_freq_high <= write_data;
          ADDR_NOISE_LENGTH: noise_length <= write_data;
          ADDR_NOISE_ENV:    noise_envelope <= write_data;
          ADDR_NOISE_DIV:    noise_divider <= write_data;
          ADDR_NOISE_TRIG:   noise_trigger_reg <= write_data;
          ADDR_MASTER_VOL:   master_volume <= write_data;
          ADDR_PANNING:      panning <= write_data;
          default: ;
        endcase
      end else begin
        // Channel writes are dropped while the unit is powered off.
      end
    end
  end

  // The frequency-low registers are write-only, so they never reach the
  // read side; their values are kept only as storage.
  always_comb begin
    regs.sq1_sweep         = sq1_sweep;
    regs.sq1_duty_length   = sq1_duty_length;
    regs.sq1_envelope      = sq1_envelope;
    regs.sq1_freq_high     = sq1_freq_high;
    regs.sq2_duty_length   = sq2_duty_length;
    regs.sq2_envelope      = sq2_envelope;
    regs.sq2_freq_high     = sq2_freq_high;
    regs.wav_dac_control   = wav_dac_control;
    regs.wav_length        = wav_length;
    regs.wav_level         = wav_level;
    regs.wav_freq_high     = wav_freq_high;
    regs.noise_length      = noise_length;
    regs.noise_envelope    = noise_envelope;
    regs.noise_divider     = noise_divider;
    regs.noise_trigger_reg = noise_trigger_reg;
    regs.master_volume     = master_volume;
    regs.panning           = panning;
    regs.power_status      = power_status;
    regs.wave_memory       = wave_memory;
  end

  a_power_down_clears: assert property (@(posedge clk) disable iff (rst)
    (wr_en && address == ADDR_POWER && !write_data[POWER_BIT]) |=>
      (power_status == 8'h00 && master_volume == 8'h00 && sq1_freq_high == 8'h00))
    else $error("power-down write did not clear the registers");

  a_unpowered_write_ignored: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !power_on && address == ADDR_SQ1_SWEEP) |=> $stable(sq1_sweep))
    else $error("channel register changed while powered off");

  a_wave_write_keeps_power: assert property (@(posedge clk) disable iff (rst)
    (wr_en && address[15:4] == WAVE_PAGE) |=> $stable(power_status))
    else $error("wave memory write disturbed the power register");

endmodule

// ===== rtl/core/snd_rf_read.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound unit read multiplexer
// Selects the addressed register through its read mask, or 0xFF for an
// unmapped or write-only address.
// ----------------------------------------------------------------------------
module snd_rf_read
  import snd_rf_pkg::*;
(
  input  regs_t       regs,
  input  logic [15:0] address,
  output logic [7:0]  read_data
);

  always_comb begin
    if (address[15:4] == WAVE_PAGE) begin
      read_data = {4'h0, regs.wave_memory[address[3:0]]};
    end else begin
      unique case (address)
        ADDR_SQ1_SWEEP:    read_data = regs.sq1_sweep;
        ADDR_SQ1_DUTY:     read_data = regs.sq1_duty_length & MASK_DUTY;
        ADDR_SQ1_ENV:      read_data = regs.sq1_envelope;
        ADDR_SQ1_FREQ_HI:  read_data = regs.sq1_freq_high & MASK_TRIGGER;
        ADDR_SQ2_DUTY:     read_data = regs.sq2_duty_length & MASK_DUTY;
        ADDR_SQ2_ENV:      read_data = regs.sq2_envelope;
        ADDR_SQ2_FREQ_HI:  read_data = regs.sq2_freq_high & MASK_TRIGGER;
        ADDR_WAV_DAC:      read_data = regs.wav_dac_control & MASK_DAC;
        ADDR_WAV_LENGTH:   read_data = regs.wav_length;
        ADDR_WAV_LEVEL:    read_data = regs.wav_level & MASK_LEVEL;
        ADDR_WAV_FREQ_HI:  read_data = regs.wav_freq_high & MASK_TRIGGER;
        ADDR_NOISE_LENGTH: read_data = regs.noise_length;
        ADDR_NOISE_ENV:    read_data = regs.noise_envelope;
        ADDR_NOISE_DIV:    read_data = regs.noise_divider;
        ADDR_NOISE_TRIG:   read_data = regs.noise_trigger_reg & MASK_TRIGGER;
        ADDR_MASTER_VOL:   read_data = regs.master_volume;
        ADDR_PANNING:      read_data = regs.panning;
        ADDR_POWER:        read_data = regs.power_status;
        default:           read_data = UNMAPPED;
      endcase
    end
  end

endmodule

// ===== rtl/core/sound_unit_register_file.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound unit register file
// Bus interface of the sound unit: register window 0xFF10 to 0xFF3F.
//
//   Port group     Direction  Handshake          Contents
//   command        in         start / busy       mode, address, write_data
//   read result    out        done (one cycle)   read_data
//
// A transaction is taken at any edge with start high; busy is never raised.
// It is registered, then decoded and applied in the following cycle; a read
// result is registered once more before it is shown on done and read_data.
// One transaction per cycle is sustained; writes produce no result.
// Synchronous reset clears all sound unit registers and the wave memory to zero.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module sound_unit_register_file
  import snd_rf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        done,
  output logic [7:0]  read_data
);

  logic        pend;
  logic        pend_mode;
  logic [15:0] pend_address;
  logic [7:0]  pend_data;
  regs_t       regs;
  logic [7:0]  read_data_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
  end

  always_ff @(posedge clk) begin
    pend_mode    <= mode;
    pend_address <= address;
    pend_data    <= write_data;
  end

  snd_rf_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (pend && pend_mode),
    .address    (pend_address),
    .write_data (pend_data),
    .regs       (regs)
  );

  snd_rf_read u_read (
    .regs      (regs),
    .address   (pend_address),
    .read_data (read_data_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pend && !pend_mode;
    end
  end

  always_ff @(posedge clk) begin
    read_data <= read_data_next;
  end

  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pend && !pend_mode))
    else $error("result strobe without a pending read");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (pend && pend_mode) |=> !done)
    else $error("write transaction produced a result");

endmodule

// ===== test/sound_unit_register_file_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound unit register file testbench
// Sends bus reads and writes through the start / busy command port and keeps
// its own copy of the register window: channel registers, power status and
// wave memory. Every read result on done is checked against that copy, in
// order. Directed transactions cover power gating, read masks, triggers and
// wave memory; random traffic follows with three levels of sender idling.
// ----------------------------------------------------------------------------
module sound_unit_register_file_tb;
  import snd_rf_pkg::*;

  localparam logic        MODE_READ     = 1'b0;
  localparam logic        MODE_WRITE    = 1'b1;
  localparam logic [15:0] ADDR_WAVE_LO  = {WAVE_PAGE, 4'h0};
  localparam logic [15:0] ADDR_WAVE_HI  = {WAVE_PAGE, 4'hF};
  localparam int          STALL_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 4;

  typedef struct {
    logic [15:0] addr;
    logic [7:0]  value;
  } read_expect_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        mode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        done;
  logic [7:0]  read_data;

  // Shadow of the register window, updated as each transaction is accepted.
  logic [7:0]   reg_shadow [ADDR_SQ1_SWEEP:ADDR_POWER];
  logic [3:0]   wave_shadow [0:15];
  read_expect_t pending_reads [$];

  int gap_pct;
  int errors;
  int reads_checked;
  int writes_sent;
  int power_offs;
  int stall_cycles;

  sound_unit_register_file dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .done       (done),
    .read_data  (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] predict_read(input logic [15:0] a);
    if (a[15:4] == WAVE_PAGE) begin
      return {4'h0, wave_shadow[a[3:0]]};
    end
    case (a)
      ADDR_SQ1_SWEEP, ADDR_SQ1_ENV, ADDR_SQ2_ENV, ADDR_WAV_LENGTH, ADDR_NOISE_LENGTH,
      ADDR_NOISE_ENV, ADDR_NOISE_DIV, ADDR_MASTER_VOL, ADDR_PANNING, ADDR_POWER: begin
        return reg_shadow[a];
      end
      ADDR_SQ1_DUTY, ADDR_SQ2_DUTY: begin
        return reg_shadow[a] & MASK_DUTY;
      end
      ADDR_SQ1_FREQ_HI, ADDR_SQ2_FREQ_HI, ADDR_WAV_FREQ_HI, ADDR_NOISE_TRIG: begin
        return reg_shadow[a] & MASK_TRIGGER;
      end
      ADDR_WAV_DAC: begin
        return reg_shadow[a] & MASK_DAC;
      end
      ADDR_WAV_LEVEL: begin
        return reg_shadow[a] & MASK_LEVEL;
      end
      default: begin
        return UNMAPPED;
      end
    endcase
  endfunction

  function automatic void clear_channel_shadow();
    foreach (reg_shadow[i]) reg_shadow[i] = 8'h00;
  endfunction

  function automatic void apply_write(input logic [15:0] a, input logic [7:0] d);
    if (a[15:4] == WAVE_PAGE) begin
      wave_shadow[a[3:0]] = d[3:0];
    end else if (a == ADDR_POWER) begin
      reg_shadow[ADDR_POWER] = {d[POWER_BIT], 7'b0};
      if (!d[POWER_BIT]) begin
        clear_channel_shadow();
        power_offs++;
      end
    end else if (reg_shadow[ADDR_POWER][POWER_BIT]) begin
      case (a)
        ADDR_SQ1_SWEEP, ADDR_SQ1_DUTY, ADDR_SQ1_ENV, ADDR_SQ1_FREQ_LO, ADDR_SQ2_DUTY,
        ADDR_SQ2_ENV, ADDR_SQ2_FREQ_LO, ADDR_WAV_DAC, ADDR_WAV_LENGTH, ADDR_WAV_LEVEL,
        ADDR_WAV_FREQ_LO, ADDR_WAV_FREQ_HI, ADDR_NOISE_LENGTH, ADDR_NOISE_ENV,
        ADDR_NOISE_DIV, ADDR_NOISE_TRIG, ADDR_MASTER_VOL, ADDR_PANNING: begin
          reg_shadow[a] = d;
        end
        ADDR_SQ1_FREQ_HI: begin
          reg_shadow[a] = d;
          if (d[TRIGGER_BIT]) reg_shadow[ADDR_POWER][SQ1_ON_BIT] = 1'b1;
        end
        ADDR_SQ2_FREQ_HI: begin
          reg_shadow[a] = d;
          if (d[TRIGGER_BIT]) reg_shadow[ADDR_POWER][SQ2_ON_BIT] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask

  // Presents one transaction, possibly after an idle gap, and updates the
  // shadow at the edge that accepts it. start is left high for the caller.
  task automatic issue_access(input logic m, input logic [15:0] a, input logic [7:0] d);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= m;
    address    <= a;
    write_data <= d;
    do @(posedge clk); while (busy);
    if (m == MODE_READ) begin
      pending_reads.push_back('{addr: a, value: predict_read(a)});
    end else begin
      apply_write(a, d);
      writes_sent++;
    end
  endtask

  always @(posedge clk) begin
    read_expect_t exp_read;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("read result 0x%02h with no read outstanding", read_data));
      end else begin
        exp_read = pending_reads.pop_front();
        reads_checked++;
        if (read_data !== exp_read.value) begin
          report_mismatch($sformatf("read of 0x%04h gave 0x%02h, expected 0x%02h",
                                    exp_read.addr, read_data, exp_read.value));
        end
      end
    end
  end

  // Ends the run if neither a transaction nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("sound_unit_register_file_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_after_reset();
    issue_access(MODE_READ, ADDR_POWER, 8'hFF);
    issue_access(MODE_READ, ADDR_SQ1_FREQ_LO, 8'h00);
    issue_access(MODE_READ, ADDR_SQ1_DUTY, 8'hFF);
    issue_access(MODE_READ, 16'hFF15, 8'h00);
    issue_access(MODE_READ, 16'hFFFF, 8'hFF);
    issue_access(MODE_READ, 16'h0000, 8'h00);
  endtask

  task automatic test_power_gating();
    // Channel writes before power-up must be dropped.
    issue_access(MODE_WRITE, ADDR_SQ1_ENV, 8'hFF);
    issue_access(MODE_READ, ADDR_SQ1_ENV, 8'h00);
    issue_access(MODE_WRITE, ADDR_POWER, 8'hFF);
    issue_access(MODE_READ, ADDR_POWER, 8'h00);
    issue_access(MODE_WRITE, ADDR_SQ1_DUTY, 8'hFF);
    issue_access(MODE_READ, ADDR_SQ1_DUTY, 8'h00);
    issue_access(MODE_WRITE, ADDR_WAV_LEVEL, 8'hFF);
    issue_access(MODE_READ, ADDR_WAV_LEVEL, 8'h00);
  endtask

  task automatic test_triggers();
    // Only channels 1 and 2 raise an enable flag in the power register.
    issue_access(MODE_WRITE, ADDR_SQ1_FREQ_HI, 8'hFF);
    issue_access(MODE_WRITE, ADDR_SQ2_FREQ_HI, 8'h80);
    issue_access(MODE_WRITE, ADDR_WAV_FREQ_HI, 8'h80);
    issue_access(MODE_WRITE, ADDR_NOISE_TRIG, 8'hFF);
    issue_access(MODE_READ, ADDR_POWER, 8'h00);
    issue_access(MODE_READ, ADDR_SQ1_FREQ_HI, 8'h00);
    issue_access(MODE_READ, ADDR_NOISE_TRIG, 8'h00);
  endtask

  task automatic test_wave_and_power_off();
    issue_access(MODE_WRITE, ADDR_WAVE_HI, 8'hFF);
    issue_access(MODE_WRITE, ADDR_WAVE_LO, 8'h5A);
    issue_access(MODE_WRITE, ADDR_POWER, 8'h7F);
    issue_access(MODE_READ, ADDR_SQ1_DUTY, 8'h00);
    issue_access(MODE_READ, ADDR_WAVE_HI, 8'h00);
    issue_access(MODE_READ, ADDR_WAVE_LO, 8'h00);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    logic        m;
    logic [15:0] a;
    logic [7:0]  d;
    int          pick;
    gap_pct = idle_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        a = 16'($urandom_range(16'hFFFF));
      end else if (pick < 16) begin
        a = ADDR_POWER;
      end else begin
        a = 16'($urandom_range(ADDR_SQ1_SWEEP, ADDR_WAVE_HI));
      end
      m = 1'($urandom_range(1));
      d = 8'($urandom_range(255));
      // Keep the unit powered most of the time so that channel writes land.
      if (a == ADDR_POWER && m == MODE_WRITE && $urandom_range(99) < 80) begin
        d[POWER_BIT] = 1'b1;
      end
      issue_access(m, a, d);
    end
  endtask

  initial begin
    errors        = 0;
    reads_checked = 0;
    writes_sent   = 0;
    power_offs    = 0;
    stall_cycles  = 0;
    gap_pct       = 32;
    clear_channel_shadow();
    foreach (wave_shadow[i]) wave_shadow[i] = 4'h0;
    rst        <= 1'b1;
    start      <= 1'b0;
    mode       <= MODE_READ;
    address    <= 16'h0000;
    write_data <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_power_gating();
    test_triggers();
    test_wave_and_power_off();
    test_random_traffic(620, 32);
    test_random_traffic(620, 88);
    test_random_traffic(620, 0);

    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_reads.size() != 0) begin
      report_mismatch($sformatf("%0d reads never answered", pending_reads.size()));
    end

    $display("Covered %0d checked reads and %0d writes, %0d of them powering the unit off.",
             reads_checked, writes_sent, power_offs);
    $display("Sender idling ran at 32, 88 and 0 percent; %0d mismatches seen.", errors);
    if (errors == 0) begin
      $display("sound_unit_register_file_tb: done, clean");
    end else begin
      $display("sound_unit_register_file_tb: done, errors");
    end
    $finish;
  end

endmodule
